// ----- hw/rtl/tlms_pkg.sv -----
`default_nettype none

package tlms_pkg;

    localparam int unsigned NUM_LIGHTS = 2;
    localparam int unsigned MODE_W     = 4;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned TIMER_W    = 16;
    localparam int unsigned PRESS_W    = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_LENGTH  = 2'd2;

    localparam logic [PRESS_W-1:0] SHORT_LIMIT_RST  = 8'd30;
    localparam logic [PRESS_W-1:0] MEDIUM_LIMIT_RST = 8'd70;
    localparam logic [TIMER_W-1:0] TICK_LENGTH_RST  = 16'd500;

    localparam logic [MODE_W-1:0] M_MOON   = 4'd1;
    localparam logic [MODE_W-1:0] M_LOW    = 4'd2;
    localparam logic [MODE_W-1:0] M_MID    = 4'd3;
    localparam logic [MODE_W-1:0] M_HIGH   = 4'd4;
    localparam logic [MODE_W-1:0] M_TURBO  = 4'd5;
    localparam logic [MODE_W-1:0] M_BLINK  = 4'd6;
    localparam logic [MODE_W-1:0] M_OFF    = 4'd9;

    typedef struct packed {
        logic load;
        logic tick;
        logic advance;
        logic home;
    } t_light_cmd;

    function automatic logic mode_two_step(input logic [MODE_W-1:0] m);
        logic r;
        case (m)
            M_TURBO, M_BLINK: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [LEVEL_W-1:0] mode_level(input logic [MODE_W-1:0] m,
                                                      input logic s);
        logic [LEVEL_W-1:0] r;
        case (m)
            M_MOON, M_OFF: r = 8'd3;
            M_LOW:         r = 8'd15;
            M_MID:         r = 8'd128;
            M_HIGH:        r = 8'd180;
            M_TURBO:       r = s ? 8'd180 : 8'd255;
            M_BLINK:       r = s ? 8'd0 : 8'd170;
            default:       r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [TIMER_W-1:0] mode_timeout(input logic [MODE_W-1:0] m,
                                                        input logic s);
        logic [TIMER_W-1:0] r;
        case (m)
            M_TURBO: r = s ? 16'd0 : 16'd30000;
            M_BLINK: r = s ? 16'd400 : 16'd100;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [MODE_W-1:0] group_next(input logic light,
                                                     input logic [MODE_W-1:0] m);
        logic [MODE_W-1:0] r;
        case (m)
            M_MOON:   r = M_LOW;
            M_LOW:    r = M_MID;
            M_MID:    r = M_HIGH;
            M_HIGH:   r = light ? M_BLINK : M_TURBO;
            default:  r = M_MOON;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tlms_in_if.sv -----
`default_nettype none

interface tlms_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] press_value;

    modport source (output valid, output operation, output press_value, input ready);
    modport sink   (input valid, input operation, input press_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tlms_out_if.sv -----
`default_nettype none

interface tlms_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] light_one_level;
    logic [7:0] light_two_level;
    logic       save_request;
    logic [7:0] saved_modes;

    modport source (output valid, output light_one_level, output light_two_level,
                    output save_request, output saved_modes, input ready);
    modport sink   (input valid, input light_one_level, input light_two_level,
                    input save_request, input saved_modes, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tlms_light.sv -----
`default_nettype none

module tlms_light #(
    parameter int unsigned LIGHT_ID = 0
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  tlms_pkg::t_light_cmd         i_cmd,
    input  wire [tlms_pkg::TIMER_W-1:0]  i_tick_length,
    output logic [tlms_pkg::LEVEL_W-1:0] o_level,
    output logic [tlms_pkg::MODE_W-1:0]  o_mode
);
    import tlms_pkg::*;

    logic [MODE_W-1:0]  r_mode, n_mode;
    logic               r_step, n_step;
    logic [TIMER_W-1:0] r_count, n_count;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic               two_step;
    logic               s_eff;

    assign two_step = mode_two_step(r_mode);
    assign s_eff    = r_step & two_step;

    always_comb begin
        n_mode  = r_mode;
        n_step  = r_step;
        n_count = r_count;
        n_level = r_level;
        if (i_cmd.tick) begin
            if (r_count < i_tick_length) begin
                n_level = mode_level(r_mode, s_eff);
                n_count = mode_timeout(r_mode, s_eff);
                n_step  = two_step & ~s_eff;
            end else begin
                n_count = r_count - i_tick_length;
            end
        end else if (i_cmd.advance) begin
            n_mode  = group_next(1'(LIGHT_ID), r_mode);
            n_step  = 1'b0;
            n_count = 16'd1;
        end else if (i_cmd.home) begin
            n_mode  = M_MOON;
            n_step  = 1'b0;
            n_count = 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_MOON;
            r_step  <= 1'b0;
            r_count <= 16'd1;
            r_level <= '0;
        end else if (i_cmd.load) begin
            r_mode  <= n_mode;
            r_step  <= n_step;
            r_count <= n_count;
            r_level <= n_level;
        end
    end

    assign o_level = r_level;
    assign o_mode  = r_mode;
endmodule

`default_nettype wire

// ----- hw/rtl/two_led_mode_sequencer.sv -----
// Two-light mode sequencer.
// Request channel i_in: operation 0 is a timer tick, 1 a button press with
// press_value. Result channel o_out: one result per request, carrying both
// PWM levels, the save flag (set after a press) and the packed mode byte
// (light one in the high nibble, light two in the low nibble).
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is high
// (0 short press limit, 1 medium press limit, 2 tick length); write only
// while no request is in flight.
// Flow: a request accepted into the input register moves into the light state
// registers, which hold the result, once the result channel can take it.
// Throughput: one request per cycle while the receiver keeps ready high; the
// input register and the light state registers form a two-stage pipeline, the
// light state doubling as the result register.
// Reset: both lights in moon mode, level 0, timers at 1, limits 30/70,
// tick length 500, both channels empty.
// Stall: while the receiver holds ready low the result holds; one more request
// is taken into the input register, then i_in.ready drops.
`default_nettype none

module two_led_mode_sequencer (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [tlms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [tlms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tlms_in_if.sink                        i_in,
    tlms_out_if.source                     o_out
);
    import tlms_pkg::*;

    logic [PRESS_W-1:0] r_short_limit;
    logic [PRESS_W-1:0] r_medium_limit;
    logic [TIMER_W-1:0] r_tick_length;

    logic               r_in_valid;
    logic               r_in_op;
    logic [PRESS_W-1:0] r_in_pv;
    logic               r_out_valid;
    logic               r_save;

    logic               advance;
    logic               is_press;
    logic               is_short;
    logic               is_medium;

    t_light_cmd         cmd [NUM_LIGHTS];
    logic [LEVEL_W-1:0] level [NUM_LIGHTS];
    logic [MODE_W-1:0]  mode [NUM_LIGHTS];

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign is_press  = (r_in_op == OP_PRESS);
    assign is_short  = (r_in_pv < r_short_limit);
    assign is_medium = !is_short && (r_in_pv < r_medium_limit);

    always_comb begin
        cmd[0].load    = advance;
        cmd[0].tick    = !is_press;
        cmd[0].advance = is_press && is_short;
        cmd[0].home    = is_press && !is_short && !is_medium;
        cmd[1].load    = advance;
        cmd[1].tick    = !is_press;
        cmd[1].advance = is_press && is_medium;
        cmd[1].home    = is_press && !is_short && !is_medium;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_limit  <= SHORT_LIMIT_RST;
            r_medium_limit <= MEDIUM_LIMIT_RST;
            r_tick_length  <= TICK_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SHORT_LIMIT:  r_short_limit  <= i_cfg_data[PRESS_W-1:0];
                REG_MEDIUM_LIMIT: r_medium_limit <= i_cfg_data[PRESS_W-1:0];
                REG_TICK_LENGTH:  r_tick_length  <= i_cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op <= i_in.operation;
            r_in_pv <= i_in.press_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_save      <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_save      <= is_press;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < NUM_LIGHTS; g++) begin : g_light
        tlms_light #(
            .LIGHT_ID (g)
        ) u_light (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd[g]),
            .i_tick_length (r_tick_length),
            .o_level       (level[g]),
            .o_mode        (mode[g])
        );
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.light_one_level = level[0];
    assign o_out.light_two_level = level[1];
    assign o_out.save_request    = r_save;
    assign o_out.saved_modes     = {mode[0], mode[1]};
endmodule

`default_nettype wire
